@@ sv/srle_pkg.sv @@
// Shared types and constants for the sprite transparency RLE encoder.
`timescale 1ns / 1ps
package srle_pkg;

   localparam int MAX_RUN_DEFAULT = 126;
   localparam int RUN_W           = 7;
   localparam int BYTE_W          = 8;
   localparam int PACK_BYTES      = 8;
   localparam int PACK_W          = PACK_BYTES * BYTE_W;
   localparam int COUNT_W         = 4;
   localparam int LEN_W           = 24;

   localparam logic [RUN_W-1:0]   RUN_LIMIT_RESET = 7'd126;
   localparam logic [LEN_W-1:0]   HEADER_BYTES    = 24'd20;
   localparam logic [LEN_W-1:0]   LEN_MAX         = 24'hFFFFFF;
   localparam logic [BYTE_W-1:0]  TRN_FLAG        = 8'h80;
   localparam logic [COUNT_W-1:0] PACK_FULL       = 4'd8;

   typedef enum logic [1:0] {
      RUN_NONE = 2'd0,
      RUN_TRN  = 2'd1,
      RUN_OPQ  = 2'd2
   } run_kind_type;

   typedef enum logic [1:0] {
      SEL_NONE = 2'd0,
      SEL_HDR  = 2'd1,
      SEL_LIT  = 2'd2
   } byte_sel_type;

   typedef struct packed {
      logic         load_pixel;
      byte_sel_type put_sel;
      logic         clear_run;
      logic         join_run;
      logic         flush;
   } dp_cmd_type;

   typedef struct packed {
      logic need_close;
      logic run_opaque;
      logic lit_last;
      logic can_put;
      logic out_free;
      logic acc_empty;
      logic joined;
      logic pix_fend;
   } dp_sts_type;

endpackage

@@ sv/srle_if.sv @@
// Pixel and packed-byte channel interfaces.
`timescale 1ns / 1ps
interface srle_req_if;
   logic       valid;
   logic       ready;
   logic       opaque;
   logic [7:0] color_index;
   logic       frame_end;

   modport source (output valid, opaque, color_index, frame_end, input ready);
   modport sink   (input valid, opaque, color_index, frame_end, output ready);
endinterface

interface srle_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [srle_pkg::PACK_W-1:0]         packed_bytes;
   logic [srle_pkg::COUNT_W-1:0]        byte_count;
   logic                                frame_done;
   logic [srle_pkg::LEN_W-1:0]          frame_length;
   logic                                last;

   modport source (output valid, packed_bytes, byte_count, frame_done, frame_length, last,
                   input ready);
   modport sink   (input valid, packed_bytes, byte_count, frame_done, frame_length, last,
                   output ready);
endinterface

@@ sv/srle_datapath.sv @@
// Datapath: run state, literal memory, byte packer, frame length and output register.
`timescale 1ns / 1ps
module srle_datapath #(
   parameter int MAX_RUN = srle_pkg::MAX_RUN_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [srle_pkg::RUN_W-1:0]       csr_wr_data,
   input  logic                             pix_opaque,
   input  logic [srle_pkg::BYTE_W-1:0]      pix_index,
   input  logic                             pix_fend,
   input  srle_pkg::dp_cmd_type             cmd,
   output srle_pkg::dp_sts_type             sts,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [srle_pkg::PACK_W-1:0]      out_bytes,
   output logic [srle_pkg::COUNT_W-1:0]     out_count,
   output logic                             out_done,
   output logic [srle_pkg::LEN_W-1:0]       out_length,
   output logic                             out_last
);

   localparam int ADDR_W = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
   localparam logic [srle_pkg::RUN_W-1:0] MAX_RUN_V = srle_pkg::RUN_W'(MAX_RUN);

   logic [srle_pkg::RUN_W-1:0]    run_limit_ff, run_limit_in;
   srle_pkg::run_kind_type        run_kind_ff, run_kind_in;
   logic [srle_pkg::RUN_W-1:0]    run_len_ff, run_len_in;
   logic [srle_pkg::RUN_W-1:0]    lit_idx_ff, lit_idx_in;
   logic                          joined_ff, joined_in;
   logic                          pix_opaque_ff;
   logic [srle_pkg::BYTE_W-1:0]   pix_index_ff;
   logic                          pix_fend_ff;
   logic [srle_pkg::LEN_W-1:0]    frame_bytes_ff, frame_bytes_in;
   logic [srle_pkg::PACK_W-1:0]   acc_ff, acc_in;
   logic [srle_pkg::COUNT_W-1:0]  acc_cnt_ff, acc_cnt_in;
   logic [srle_pkg::BYTE_W-1:0]   rd_data_ff;
   logic [srle_pkg::BYTE_W-1:0]   mem [MAX_RUN];

   logic                          out_valid_ff, out_valid_in;
   logic [srle_pkg::PACK_W-1:0]   out_bytes_ff, out_bytes_in;
   logic [srle_pkg::COUNT_W-1:0]  out_count_ff, out_count_in;
   logic                          out_done_ff, out_done_in;
   logic [srle_pkg::LEN_W-1:0]    out_length_ff, out_length_in;
   logic                          out_last_ff, out_last_in;

   logic [srle_pkg::RUN_W-1:0]    eff_lim;
   srle_pkg::run_kind_type        pix_kind;
   logic [srle_pkg::RUN_W-1:0]    len_base;
   logic [srle_pkg::BYTE_W-1:0]   hdr_byte;
   logic [srle_pkg::BYTE_W-1:0]   put_byte;
   logic                          put;
   logic                          out_free;
   logic                          can_put;
   logic                          wr_en;
   logic [ADDR_W-1:0]             wr_addr;
   logic [ADDR_W-1:0]             rd_addr;

   assign pix_kind = pix_opaque_ff ? srle_pkg::RUN_OPQ : srle_pkg::RUN_TRN;
   assign out_free = !out_valid_ff || out_ready;
   assign can_put  = (acc_cnt_ff != srle_pkg::PACK_FULL) || out_free;
   assign put      = (cmd.put_sel != srle_pkg::SEL_NONE) && can_put;
   assign len_base = (run_kind_ff == srle_pkg::RUN_NONE) ? '0 : run_len_ff;
   assign hdr_byte = (run_kind_ff == srle_pkg::RUN_TRN) ?
                     (srle_pkg::TRN_FLAG | {1'b0, run_len_ff}) : {1'b0, run_len_ff};
   assign put_byte = (cmd.put_sel == srle_pkg::SEL_LIT) ? rd_data_ff : hdr_byte;
   assign wr_en    = cmd.join_run && pix_opaque_ff && (len_base < MAX_RUN_V);
   assign wr_addr  = len_base[ADDR_W-1:0];
   assign rd_addr  = (lit_idx_in < MAX_RUN_V) ? lit_idx_in[ADDR_W-1:0] : '0;

   always_comb begin
      eff_lim = run_limit_ff;
      if (eff_lim == '0) begin
         eff_lim = srle_pkg::RUN_W'(1);
      end
      if (eff_lim > MAX_RUN_V) begin
         eff_lim = MAX_RUN_V;
      end
   end

   always_comb begin
      sts.need_close = (run_kind_ff != srle_pkg::RUN_NONE) &&
                       (joined_ff || (run_kind_ff != pix_kind) || (run_len_ff >= eff_lim));
      sts.run_opaque = (run_kind_ff == srle_pkg::RUN_OPQ);
      sts.lit_last   = (lit_idx_ff == (run_len_ff - srle_pkg::RUN_W'(1)));
      sts.can_put    = can_put;
      sts.out_free   = out_free;
      sts.acc_empty  = (acc_cnt_ff == '0);
      sts.joined     = joined_ff;
      sts.pix_fend   = pix_fend_ff;
   end

   always_comb begin
      run_limit_in   = csr_wr_en ? csr_wr_data : run_limit_ff;
      run_kind_in    = run_kind_ff;
      run_len_in     = run_len_ff;
      lit_idx_in     = lit_idx_ff;
      joined_in      = joined_ff;
      frame_bytes_in = frame_bytes_ff;
      acc_in         = acc_ff;
      acc_cnt_in     = acc_cnt_ff;
      out_valid_in   = out_valid_ff && !out_ready;
      out_bytes_in   = out_bytes_ff;
      out_count_in   = out_count_ff;
      out_done_in    = out_done_ff;
      out_length_in  = out_length_ff;
      out_last_in    = out_last_ff;

      if (cmd.load_pixel) begin
         joined_in = 1'b0;
      end

      if (cmd.join_run) begin
         run_kind_in = pix_kind;
         run_len_in  = (len_base != '1) ? len_base + srle_pkg::RUN_W'(1) : len_base;
         joined_in   = 1'b1;
      end

      if (put) begin
         if (frame_bytes_ff != srle_pkg::LEN_MAX) begin
            frame_bytes_in = frame_bytes_ff + srle_pkg::LEN_W'(1);
         end
         if (cmd.put_sel == srle_pkg::SEL_LIT) begin
            lit_idx_in = lit_idx_ff + srle_pkg::RUN_W'(1);
         end
         if (acc_cnt_ff == srle_pkg::PACK_FULL) begin
            out_valid_in  = 1'b1;
            out_bytes_in  = acc_ff;
            out_count_in  = acc_cnt_ff;
            out_done_in   = 1'b0;
            out_length_in = '0;
            out_last_in   = 1'b0;
         end
         if ((acc_cnt_ff == '0) || (acc_cnt_ff == srle_pkg::PACK_FULL)) begin
            acc_in     = {{(srle_pkg::PACK_W - srle_pkg::BYTE_W){1'b0}}, put_byte};
            acc_cnt_in = srle_pkg::COUNT_W'(1);
         end else begin
            for (int i = 1; i < srle_pkg::PACK_BYTES; i++) begin
               if (acc_cnt_ff == srle_pkg::COUNT_W'(i)) begin
                  acc_in[i*srle_pkg::BYTE_W +: srle_pkg::BYTE_W] = put_byte;
               end
            end
            acc_cnt_in = acc_cnt_ff + srle_pkg::COUNT_W'(1);
         end
      end

      if (cmd.clear_run) begin
         run_kind_in = srle_pkg::RUN_NONE;
         run_len_in  = '0;
         lit_idx_in  = '0;
      end

      if (cmd.flush && out_free) begin
         out_valid_in  = 1'b1;
         out_bytes_in  = acc_ff;
         out_count_in  = acc_cnt_ff;
         out_done_in   = pix_fend_ff;
         out_length_in = pix_fend_ff ? frame_bytes_ff : '0;
         out_last_in   = 1'b1;
         acc_cnt_in    = '0;
         if (pix_fend_ff) begin
            frame_bytes_in = srle_pkg::HEADER_BYTES;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_limit_ff   <= srle_pkg::RUN_LIMIT_RESET;
         run_kind_ff    <= srle_pkg::RUN_NONE;
         run_len_ff     <= '0;
         lit_idx_ff     <= '0;
         joined_ff      <= 1'b0;
         frame_bytes_ff <= srle_pkg::HEADER_BYTES;
         acc_cnt_ff     <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         run_limit_ff   <= run_limit_in;
         run_kind_ff    <= run_kind_in;
         run_len_ff     <= run_len_in;
         lit_idx_ff     <= lit_idx_in;
         joined_ff      <= joined_in;
         frame_bytes_ff <= frame_bytes_in;
         acc_cnt_ff     <= acc_cnt_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_pixel) begin
         pix_opaque_ff <= pix_opaque;
         pix_index_ff  <= pix_index;
         pix_fend_ff   <= pix_fend;
      end
      acc_ff        <= acc_in;
      out_bytes_ff  <= out_bytes_in;
      out_count_ff  <= out_count_in;
      out_done_ff   <= out_done_in;
      out_length_ff <= out_length_in;
      out_last_ff   <= out_last_in;
   end

   // literal store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= pix_index_ff;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign out_valid  = out_valid_ff;
   assign out_bytes  = out_bytes_ff;
   assign out_count  = out_count_ff;
   assign out_done   = out_done_ff;
   assign out_length = out_length_ff;
   assign out_last   = out_last_ff;

endmodule

@@ sv/srle_ctrl.sv @@
// Controller: sequences pixel load, run close, literal drain and result flush.
`timescale 1ns / 1ps
module srle_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  srle_pkg::dp_sts_type  sts,
   output srle_pkg::dp_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_LIT,
      ST_FLUSH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      cmd.load_pixel = 1'b0;
      cmd.put_sel   = srle_pkg::SEL_NONE;
      cmd.clear_run = 1'b0;
      cmd.join_run  = 1'b0;
      cmd.flush     = 1'b0;
      req_ready     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_pixel = 1'b1;
               state_in       = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (sts.need_close) begin
               cmd.put_sel = srle_pkg::SEL_HDR;
               if (sts.can_put) begin
                  if (sts.run_opaque) begin
                     state_in = ST_LIT;
                  end else begin
                     cmd.clear_run = 1'b1;
                  end
               end
            end else if (!sts.joined) begin
               cmd.join_run = 1'b1;
               if (sts.pix_fend) begin
                  state_in = ST_EVAL;
               end else if (sts.acc_empty) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_FLUSH;
               end
            end else begin
               state_in = ST_FLUSH;
            end
         end
         ST_LIT: begin
            cmd.put_sel = srle_pkg::SEL_LIT;
            if (sts.can_put && sts.lit_last) begin
               cmd.clear_run = 1'b1;
               state_in      = ST_EVAL;
            end
         end
         ST_FLUSH: begin
            cmd.flush = 1'b1;
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ sv/sprite_transparency_rle_encoder_core.sv @@
// Top level of the sprite transparency run-length encoder.
// Channels: req_chan takes one pixel per beat (opaque flag, color index, frame end);
// rsp_chan gives up to eight encoded bytes per beat, first byte in bits 7:0, with
// byte_count, last (final beat caused by the pixel), and frame_done / frame_length
// on the final beat of a frame. csr_wr_en / csr_wr_data write run_limit.
// Sequence: a pixel that only extends a run is accepted, then joined, and gives
// no beat. Closing a run puts out the header byte, then for an opaque run one
// literal a cycle from the literal store's registered read port while the packer
// can take a byte; a pixel with bytes then flushes what is left in the packer as
// its final beat. On frame end the run is closed after the join.
// The last beat is valid at the edge that ends the pixel's final cycle; the next
// pixel is taken in the following cycle.
// Reset clears run state, sets run_limit to 126 and the frame length to 20; the
// literal store is not cleared; every entry is written before its byte is sent.
// A stalled receiver holds the output register; the encoder keeps working until a
// ninth byte or the flush needs the register, then waits. A new pixel is taken
// while the last beat of the previous one is still waiting.
`timescale 1ns / 1ps
module sprite_transparency_rle_encoder_core #(
   parameter int MAX_RUN = srle_pkg::MAX_RUN_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   srle_req_if.sink                    req_chan,
   srle_rsp_if.source                  rsp_chan,
   input  logic                        csr_wr_en,
   input  logic [srle_pkg::RUN_W-1:0]  csr_wr_data
);

   srle_pkg::dp_cmd_type cmd;
   srle_pkg::dp_sts_type sts;

   srle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   srle_datapath #(
      .MAX_RUN (MAX_RUN)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .pix_opaque  (req_chan.opaque),
      .pix_index   (req_chan.color_index),
      .pix_fend    (req_chan.frame_end),
      .cmd         (cmd),
      .sts         (sts),
      .out_valid   (rsp_chan.valid),
      .out_ready   (rsp_chan.ready),
      .out_bytes   (rsp_chan.packed_bytes),
      .out_count   (rsp_chan.byte_count),
      .out_done    (rsp_chan.frame_done),
      .out_length  (rsp_chan.frame_length),
      .out_last    (rsp_chan.last)
   );

   // new pixel only once the previous one's bytes have all left the packer
   a_accept_packer_empty: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |-> sts.acc_empty)
      else $error("pixel accepted with bytes still in packer");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.frame_done) |-> rsp_chan.last)
      else $error("frame_done beat without last");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.byte_count != '0 &&
                          rsp_chan.byte_count <= srle_pkg::PACK_FULL))
      else $error("byte_count out of range");

   a_length_floor: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.frame_done) |->
         (rsp_chan.frame_length > srle_pkg::HEADER_BYTES))
      else $error("frame_length below header size");

endmodule
